/* rtl/cic_pkg.sv */
// Shared types and fixed field widths for the compacting issue queue.
package cic_pkg;

  localparam int TAG_W      = 4;
  localparam int PAY_W      = 32;
  localparam int MASK_W     = 16;
  localparam int FIELD_WAYS = 2;
  localparam int FIELD_FUS  = 2;

  typedef struct packed {
    logic [FIELD_WAYS-1:0] enq_valid;
    logic [PAY_W-1:0]      enq0_payload;
    logic [TAG_W-1:0]      enq0_tag;
    logic [PAY_W-1:0]      enq1_payload;
    logic [TAG_W-1:0]      enq1_tag;
    logic [FIELD_FUS-1:0]  fu_accept;
    logic                  downstream_ready;
    logic                  flush_taken;
    logic [MASK_W-1:0]     flush_mask;
  } req_t;

  typedef struct packed {
    logic [FIELD_FUS-1:0]  issue_valid;
    logic [PAY_W-1:0]      issue0_payload;
    logic [TAG_W-1:0]      issue0_tag;
    logic [PAY_W-1:0]      issue1_payload;
    logic [TAG_W-1:0]      issue1_tag;
    logic [FIELD_WAYS-1:0] enq_accept;
    logic                  all_accept;
  } res_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              step;
    logic              squeeze;
    logic              flush_taken;
    logic [MASK_W-1:0] flush_mask;
  } cell_ctrl_t;

endpackage

/* rtl/cic_cell.sv */
// One queue slot: holds an entry and moves it along the chain.
module cic_cell import cic_pkg::*; #(
  parameter int PB          = 32,
  parameter int SPAN        = 3,
  parameter int WE          = 2,
  parameter int IW          = 4,
  parameter int OW          = 5,
  parameter int IDX         = 0,
  parameter int BRANCH_TAGS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [SPAN-2:0]  fired_i,
  input  logic [OW-1:0]    tail_i,
  input  logic             hole_i,
  input  logic             win_valid_i [SPAN],
  input  logic [TAG_W-1:0] win_tag_i   [SPAN],
  input  logic [PB-1:0]    win_pay_i   [SPAN],
  input  logic             app_take_i  [WE],
  input  logic [IW-1:0]    app_pos_i   [WE],
  input  logic [TAG_W-1:0] app_tag_i   [WE],
  input  logic [PAY_W-1:0] app_pay_i   [WE],
  output logic             valid_o,
  output logic [TAG_W-1:0] tag_o,
  output logic [PB-1:0]    pay_o,
  output logic             hole_o,
  output logic             bubble_o
);

  localparam int CW = $clog2(SPAN);

  logic             valid_q, valid_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [PB-1:0]    pay_q, pay_d;

  logic             sh_valid;
  logic [TAG_W-1:0] sh_tag;
  logic [PB-1:0]    sh_pay;
  logic             kill;

  // After the fired entries leave, this slot takes the entry whose index,
  // less the fired entries below it, equals IDX.
  always_comb begin
    logic [CW-1:0] cnt;
    logic          fired_j;
    sh_valid = 1'b0;
    sh_tag   = tag_q;
    sh_pay   = pay_q;
    for (int d = 0; d < SPAN; d++) begin
      cnt     = '0;
      fired_j = 1'b0;
      for (int m = 0; m < SPAN - 1; m++) begin
        if (m < IDX + d) cnt = cnt + CW'(fired_i[m]);
        if (m == IDX + d) fired_j = fired_i[m];
      end
      if (win_valid_i[d] && !fired_j && cnt == CW'(d)) begin
        sh_valid = 1'b1;
        sh_tag   = win_tag_i[d];
        sh_pay   = win_pay_i[d];
      end
    end
  end

  assign kill = ctrl_i.flush_taken && (int'(sh_tag) < BRANCH_TAGS) &&
                ctrl_i.flush_mask[sh_tag];

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    pay_d   = pay_q;
    if (ctrl_i.step) begin
      valid_d = sh_valid && !kill;
      tag_d   = sh_tag;
      pay_d   = sh_pay;
      for (int w = 0; w < WE; w++) begin
        if (app_take_i[w] && app_pos_i[w] == IW'(IDX)) begin
          valid_d = 1'b1;
          tag_d   = app_tag_i[w];
          pay_d   = PB'(app_pay_i[w]);
        end
      end
    end else if (ctrl_i.squeeze && (hole_i || !valid_q)) begin
      // first gap at or before this slot: pull the neighbour in
      valid_d = win_valid_i[1];
      tag_d   = win_tag_i[1];
      pay_d   = win_pay_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    pay_q <= pay_d;
  end

  assign valid_o  = valid_q;
  assign tag_o    = tag_q;
  assign pay_o    = pay_q;
  assign hole_o   = hole_i || !valid_q;
  assign bubble_o = !valid_q && (tail_i > OW'(IDX));

endmodule

/* rtl/compacting_issue_queue_core.sv */
// Compacting issue queue: chain of slot cells, selection and enqueue control.
// A beat accepted on start gives its registered result on done_o in the next cycle.
// Throughput: one beat per cycle while busy is low; after a taken branch drops held
// entries, busy stays high while the chain squeezes out the gaps they leave.
// Reset clears every valid bit and the occupancy, with done_o low.
// The receiver cannot stall: each result sits on res_o for its single done_o cycle.
module compacting_issue_queue_core import cic_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int FU_NUM       = 2,
  parameter int WAYS         = 2,
  parameter int BRANCH_TAGS  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output res_t res_o,
  output logic done_o
);

  localparam int FUE  = (FU_NUM < FIELD_FUS) ? FU_NUM : FIELD_FUS;
  localparam int WE   = (WAYS < FIELD_WAYS) ? WAYS : FIELD_WAYS;
  localparam int PB   = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int SPAN = FUE + 1;
  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int OW   = $clog2(QUEUE_DEPTH + 1);

  cell_ctrl_t ctrl;
  logic       step;

  logic             slot_valid [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag   [QUEUE_DEPTH];
  logic [PB-1:0]    slot_pay   [QUEUE_DEPTH];
  logic             hole       [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] bubble;

  logic             win_valid [QUEUE_DEPTH][SPAN];
  logic [TAG_W-1:0] win_tag   [QUEUE_DEPTH][SPAN];
  logic [PB-1:0]    win_pay   [QUEUE_DEPTH][SPAN];

  logic [FUE-1:0]   fired;
  logic [OW-1:0]    nfired, live;
  logic             app_take [WE];
  logic [IW-1:0]    app_pos  [WE];
  logic [TAG_W-1:0] app_tag  [WE];
  logic [PAY_W-1:0] app_pay  [WE];
  logic [FIELD_WAYS-1:0] acc;
  logic [OW-1:0]    tail_q, tail_d, taken_cnt;

  res_t res_q, res_d;
  logic done_q;

  assign busy = |bubble;
  assign step = start && !busy;

  always_comb begin
    ctrl.step        = step;
    ctrl.squeeze     = busy;
    ctrl.flush_taken = req_i.flush_taken;
    ctrl.flush_mask  = req_i.flush_mask;
  end

  assign hole[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    for (genvar d = 0; d < SPAN; d++) begin : g_win
      if (i + d < QUEUE_DEPTH) begin : g_in
        assign win_valid[i][d] = slot_valid[i+d];
        assign win_tag[i][d]   = slot_tag[i+d];
        assign win_pay[i][d]   = slot_pay[i+d];
      end else begin : g_end
        assign win_valid[i][d] = 1'b0;
        assign win_tag[i][d]   = '0;
        assign win_pay[i][d]   = '0;
      end
    end

    cic_cell #(
      .PB          (PB),
      .SPAN        (SPAN),
      .WE          (WE),
      .IW          (IW),
      .OW          (OW),
      .IDX         (i),
      .BRANCH_TAGS (BRANCH_TAGS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .fired_i     (fired),
      .tail_i      (tail_q),
      .hole_i      (hole[i]),
      .win_valid_i (win_valid[i]),
      .win_tag_i   (win_tag[i]),
      .win_pay_i   (win_pay[i]),
      .app_take_i  (app_take),
      .app_pos_i   (app_pos),
      .app_tag_i   (app_tag),
      .app_pay_i   (app_pay),
      .valid_o     (slot_valid[i]),
      .tag_o       (slot_tag[i]),
      .pay_o       (slot_pay[i]),
      .hole_o      (hole[i+1]),
      .bubble_o    (bubble[i])
    );
  end

  // Entries are packed at the front, so the oldest are the first slots.
  always_comb begin
    nfired = '0;
    for (int k = 0; k < FUE; k++) begin
      fired[k] = slot_valid[k] && req_i.fu_accept[k];
      nfired   = nfired + OW'(fired[k]);
    end
  end

  assign live = tail_q - nfired;

  always_comb begin
    logic [TAG_W-1:0] way_tag [FIELD_WAYS];
    logic [PAY_W-1:0] way_pay [FIELD_WAYS];
    way_tag[0] = req_i.enq0_tag;
    way_tag[1] = req_i.enq1_tag;
    way_pay[0] = req_i.enq0_payload;
    way_pay[1] = req_i.enq1_payload;
    taken_cnt  = '0;
    acc        = '1;
    for (int w = 0; w < WE; w++) begin
      app_pos[w]  = IW'(live + taken_cnt);
      app_tag[w]  = way_tag[w];
      app_pay[w]  = way_pay[w];
      app_take[w] = req_i.enq_valid[w] &&
                    ({1'b0, live} + {1'b0, taken_cnt} < (OW+1)'(QUEUE_DEPTH));
      if (app_take[w]) taken_cnt = taken_cnt + OW'(1);
      acc[w] = !req_i.enq_valid[w] || app_take[w];
    end
  end

  always_comb begin
    tail_d = tail_q;
    if (step) begin
      tail_d = live + taken_cnt;
    end else if (busy) begin
      tail_d = tail_q - OW'(1);
    end
  end

  always_comb begin
    res_d = '0;
    for (int k = 0; k < FUE; k++) begin
      res_d.issue_valid[k] = slot_valid[k];
    end
    if (slot_valid[0]) begin
      res_d.issue0_payload = PAY_W'(slot_pay[0]);
      res_d.issue0_tag     = slot_tag[0];
    end
    if (FUE > 1 && slot_valid[1]) begin
      res_d.issue1_payload = PAY_W'(slot_pay[1]);
      res_d.issue1_tag     = slot_tag[1];
    end
    res_d.enq_accept = acc;
    res_d.all_accept = (&acc) && req_i.downstream_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      done_q <= 1'b0;
    end else begin
      tail_q <= tail_d;
      done_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  // done marks exactly the cycle after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(step))
    else $error("done strobe out of step with accepted beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= OW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // each squeeze cycle removes exactly one gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> tail_q == $past(tail_q) - OW'(1))
    else $error("squeeze did not shrink occupancy by one");

  // when idle there is no gap at the head: an empty first slot means an empty second
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !slot_valid[0] |-> !slot_valid[1])
    else $error("gap at head of queue while not busy");

endmodule

/* sim/cic_issue_checker.sv */
// Checker for the compacting issue queue: predicts each cycle's offers and accepts, compares.
`timescale 1ns / 100ps

module cic_issue_checker import cic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  res_t res_i,
  input  logic done_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  localparam int ENTRIES = 16;
  localparam int UNITS   = 2;

  // shadow copy of the slot chain; valid slots always sit at the front
  logic [ENTRIES-1:0] slot_vld;
  logic [PAY_W-1:0]   slot_pay [ENTRIES];
  logic [TAG_W-1:0]   slot_tag [ENTRIES];
  int                 held;

  res_t expected_issue_q[$];
  int   mismatches;
  int   waiting;

  assign fail_cnt_o = mismatches;
  assign pending_o  = waiting;

  // One queue cycle: offer oldest entries, drop fired and flushed ones, squeeze,
  // then append new instructions while room remains.
  function automatic res_t predict_cycle(req_t r);
    res_t             o;
    int               sel [UNITS];
    logic [ENTRIES-1:0] gone;
    int               nsel;
    int               nfired;
    int               live;
    int               room;
    int               n;
    int               taken_cnt;
    logic [1:0]       acc;
    o         = '0;
    gone      = '0;
    nsel      = 0;
    nfired    = 0;
    taken_cnt = 0;
    acc       = '0;
    for (int i = 0; i < ENTRIES && nsel < UNITS; i++) begin
      if (slot_vld[i]) begin
        sel[nsel] = i;
        nsel++;
      end
    end
    for (int k = 0; k < nsel; k++) begin
      o.issue_valid[k] = 1'b1;
      if (k == 0) begin
        o.issue0_payload = slot_pay[sel[k]];
        o.issue0_tag     = slot_tag[sel[k]];
      end else begin
        o.issue1_payload = slot_pay[sel[k]];
        o.issue1_tag     = slot_tag[sel[k]];
      end
      if (r.fu_accept[k]) begin
        gone[sel[k]] = 1'b1;
        nfired++;
      end
    end
    // room is judged before the flush takes effect
    live = (held > nfired) ? held - nfired : 0;
    room = ENTRIES - live;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_vld[i] && !gone[i] && !(r.flush_taken && r.flush_mask[slot_tag[i]])) begin
        slot_pay[n] = slot_pay[i];
        slot_tag[n] = slot_tag[i];
        slot_vld[n] = 1'b1;
        n++;
      end
    end
    for (int w = 0; w < 2; w++) begin
      if (!r.enq_valid[w]) begin
        acc[w] = 1'b1;
      end else if (taken_cnt < room && n < ENTRIES) begin
        slot_pay[n] = (w == 0) ? r.enq0_payload : r.enq1_payload;
        slot_tag[n] = (w == 0) ? r.enq0_tag : r.enq1_tag;
        slot_vld[n] = 1'b1;
        n++;
        taken_cnt++;
        acc[w] = 1'b1;
      end
    end
    for (int i = n; i < ENTRIES; i++) slot_vld[i] = 1'b0;
    held = n;
    o.enq_accept = acc;
    o.all_accept = (&acc) && r.downstream_ready;
    return o;
  endfunction

  function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   errs;
    if (!rst_ni) begin
      slot_vld = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_pay[i] = '0;
        slot_tag[i] = '0;
      end
      held = 0;
      expected_issue_q.delete();
      mismatches = 0;
      waiting    = 0;
    end else begin
      // the result of the previous beat is checked before this edge's beat is predicted
      if (done_i === 1'b1) begin
        if (expected_issue_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, res_i);
          mismatches++;
        end else begin
          want = expected_issue_q.pop_front();
          errs = field_diff("issue_valid", 32'(want.issue_valid), 32'(res_i.issue_valid))
               + field_diff("issue0_payload", want.issue0_payload, res_i.issue0_payload)
               + field_diff("issue0_tag", 32'(want.issue0_tag), 32'(res_i.issue0_tag))
               + field_diff("issue1_payload", want.issue1_payload, res_i.issue1_payload)
               + field_diff("issue1_tag", 32'(want.issue1_tag), 32'(res_i.issue1_tag))
               + field_diff("enq_accept", 32'(want.enq_accept), 32'(res_i.enq_accept))
               + field_diff("all_accept", 32'(want.all_accept), 32'(res_i.all_accept));
          if (errs != 0) mismatches++;
        end
      end
      if (start_i && !busy_i) expected_issue_q.push_back(predict_cycle(req_i));
      waiting = expected_issue_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top: clock, reset and stimulus for the compacting issue queue, plus the verdict.
`timescale 1ns / 100ps

module tb_top;
  import cic_pkg::*;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED, FLUSHY} traffic_e;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  res_t res;
  logic done;
  int   fails;
  int   pending;

  compacting_issue_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .res_o  (res),
    .done_o (done)
  );

  cic_issue_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .res_i      (res),
    .done_i     (done),
    .fail_cnt_o (fails),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic req_t mk(logic [1:0] ev, logic [31:0] p0, logic [3:0] t0,
                              logic [31:0] p1, logic [3:0] t1, logic [1:0] fa,
                              logic rdy, logic ft, logic [15:0] fm);
    req_t r;
    r.enq_valid        = ev;
    r.enq0_payload     = p0;
    r.enq0_tag         = t0;
    r.enq1_payload     = p1;
    r.enq1_tag         = t1;
    r.fu_accept        = fa;
    r.downstream_ready = rdy;
    r.flush_taken      = ft;
    r.flush_mask       = fm;
    return r;
  endfunction

  function automatic req_t rand_beat(traffic_e mode);
    req_t r;
    r = mk(2'($urandom_range(3, 0)), $urandom, 4'($urandom_range(15, 0)), $urandom,
           4'($urandom_range(15, 0)), 2'($urandom_range(3, 0)),
           1'($urandom_range(1, 0)), 1'b0, 16'($urandom_range(16'hffff, 0)));
    unique case (mode)
      FILL_UP: begin
        if ($urandom_range(3, 0) != 0) r.enq_valid = 2'b11;
        if ($urandom_range(3, 0) != 0) r.fu_accept = 2'b00;
      end
      DRAIN_DOWN: begin
        if ($urandom_range(3, 0) != 0) r.enq_valid = 2'b00;
        if ($urandom_range(3, 0) != 0) r.fu_accept = 2'b11;
      end
      default: ;
    endcase
    r.flush_taken = (mode == FLUSHY) ? ($urandom_range(2, 0) == 0) : ($urandom_range(15, 0) == 0);
    return r;
  endfunction

  // hold the beat on the request port until the queue takes it
  task automatic issue_beat(req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic rest(int cycles);
    start <= 1'b0;
    req   <= rand_beat(MIXED);
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    traffic_e mode;
    bit       idle_on;
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: idle offers read zero, accepts with nothing offered are ignored
    issue_beat(mk(2'b00, '0, '0, '0, '0, 2'b11, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b11, 32'h0, 4'h0, 32'hffff_ffff, 4'hf, 2'b00, 1'b1, 1'b0, '0));
    for (int i = 0; i < 7; i++)
      issue_beat(mk(2'b11, $urandom, 4'(i), $urandom, 4'(15 - i), 2'b00, 1'b1, 1'b0, '0));
    // full: both ways refused, then room for exactly one
    issue_beat(mk(2'b11, $urandom, 4'h3, $urandom, 4'h4, 2'b00, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b11, $urandom, 4'h5, $urandom, 4'h6, 2'b01, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b01, $urandom, 4'h7, $urandom, 4'h8, 2'b10, 1'b0, 1'b0, '0));
    // mask without a taken branch does nothing
    issue_beat(mk(2'b11, $urandom, 4'h1, $urandom, 4'h2, 2'b00, 1'b1, 1'b0, 16'hffff));
    // flush on a full queue: acceptance still judged on the unflushed count
    issue_beat(mk(2'b11, $urandom, 4'h0, $urandom, 4'hf, 2'b00, 1'b1, 1'b1, 16'h8001));
    // flush everything held; offered entries still show, new entries survive
    issue_beat(mk(2'b11, $urandom, 4'h0, $urandom, 4'hf, 2'b11, 1'b1, 1'b1, 16'hffff));
    issue_beat(mk(2'b00, '0, '0, '0, '0, 2'b11, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b11, $urandom, 4'h9, $urandom, 4'ha, 2'b11, 1'b1, 1'b1, 16'h0000));
    issue_beat(mk(2'b10, $urandom, 4'hb, $urandom, 4'hc, 2'b01, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b00, '0, '0, '0, '0, 2'b10, 1'b1, 1'b0, '0));
    issue_beat(mk(2'b00, '0, '0, '0, '0, 2'b11, 1'b0, 1'b0, '0));
    issue_beat(mk(2'b00, '0, '0, '0, '0, 2'b11, 1'b1, 1'b0, '0));

    for (int ph = 0; ph < 20; ph++) begin
      mode    = traffic_e'($urandom_range(3, 0));
      idle_on = (ph < 17) && ($urandom_range(3, 0) != 0);
      for (int j = 0; j < 50; j++) begin
        if (idle_on && $urandom_range(5, 0) == 0) rest($urandom_range(17, 1));
        issue_beat(rand_beat(mode));
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cic_pkg.sv
rtl/cic_cell.sv
rtl/compacting_issue_queue_core.sv
sim/cic_issue_checker.sv
sim/tb_top.sv
